// ===== design/gbdi_pkg.sv =====
// Shared widths, register indexes, types and helpers for the gyro bias deadband integrator.
package gbdi_pkg;

   // Block configuration
   localparam int CAL_SAMPLES = 512;
   localparam int RATE_W      = 16;

   // Port field widths
   localparam int SAMPLE_W    = 16;
   localparam int TS_W        = 32;
   localparam int ANGLE_W     = 32;
   localparam int DEADBAND_W  = 15;
   localparam int SCALE_W     = 16;
   localparam int DT_W        = 16;
   localparam int ACC_W       = 64;
   localparam int FRAC_W      = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_DEADBAND = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE    = 4'd1;
   localparam logic [DEADBAND_W-1:0]  DEADBAND_RST = 15'd150;
   localparam logic [SCALE_W-1:0]     SCALE_RST    = 16'd500;

   // Calibration arithmetic: shift is floor(log2(CAL_SAMPLES))
   localparam int CAL_SHIFT = $clog2(CAL_SAMPLES + 1) - 1;
   localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W     = RATE_W + $clog2(CAL_SAMPLES);
   localparam int BIAS_W    = SUM_W - CAL_SHIFT;
   localparam int CORR_W    = BIAS_W + 1;
   localparam int CMP_W     = (CORR_W > DEADBAND_W) ? CORR_W : DEADBAND_W;

   // Shared shift-add multiplier: MA_W x MB_W, one multiplier bit per cycle
   localparam int MA_W   = SCALE_W + DT_W;
   localparam int MB_W   = (CORR_W > DT_W) ? CORR_W : DT_W;
   localparam int MP_W   = MA_W + MB_W;
   localparam int MCNT_W = $clog2(MB_W);

   typedef struct packed {
      logic busy;
      logic done;
   } mult_stat_type;

   // Take the low RATE_W bits of the sample as a signed value
   function automatic logic signed [RATE_W-1:0] rate_ext(input logic [SAMPLE_W-1:0] raw);
      logic [RATE_W-1:0] v;
      for (int i = 0; i < RATE_W; i++) begin
         v[i] = (i < SAMPLE_W) ? raw[i] : 1'b0;
      end
      return $signed(v);
   endfunction

endpackage

// ===== design/gyro_bias_deadband_integrator.sv =====
// Top level of the gyro yaw-rate integrator with start-up bias calibration and deadband.
//
// Channels: req_ carries one sample per beat (rate sample and millisecond timestamp),
// rsp_ returns exactly one beat per sample (angle in millidegrees, calibrating flag),
// csr_ writes deadband_counts (index 0) or angle_scale (index 1); csr_ready is always high.
// After reset the first CAL_SAMPLES beats calibrate: each goes through S_DONE, which loads
// the output register with angle 0 and the calibrating flag set once that register is free;
// the block returns to idle as it loads the result and only then takes the next sample.
// Later samples remove the bias, apply the deadband and run two passes through one
// shared shift-add multiplier (elapsed ms times scale, then times the rate magnitude),
// one multiplier bit per cycle, MB_W bits per pass (17 at the default widths), with the
// done flag of the first pass starting the second. The block takes one sample at a time
// and is ready again once the result is loaded into the output register.
// Reset puts the block back into calibration, clears the accumulated angle and reloads
// the register defaults (deadband 150, scale 500).
// A stalled receiver holds the result in the output register; the next sample is still
// accepted and processed, and its result waits until the output register frees up.
module gyro_bias_deadband_integrator (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata fields, low bit up: rate_sample[15:0], timestamp_ms[47:16]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [47:0]                       req_tdata,
   // rsp_tdata fields, low bit up: angle_mdeg[31:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,
   // rsp_tuser fields, low bit up: calibrating[0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gbdi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gbdi_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;

   logic [2:0]                             state_ff, state_in;
   logic                                   cal_active_ff, cal_active_in;
   logic [gbdi_pkg::CNT_W-1:0]             cal_count_ff, cal_count_in;
   logic signed [gbdi_pkg::SUM_W-1:0]      rate_sum_ff, rate_sum_in;
   logic signed [gbdi_pkg::BIAS_W-1:0]     bias_ff, bias_in;
   logic [gbdi_pkg::TS_W-1:0]              last_ts_ff, last_ts_in;
   logic [gbdi_pkg::DEADBAND_W-1:0]        deadband_ff, deadband_in;
   logic [gbdi_pkg::SCALE_W-1:0]           scale_ff, scale_in;
   logic [gbdi_pkg::CORR_W-1:0]            mag_ff, mag_in;
   logic                                   neg_ff, neg_in;
   logic                                   res_cal_ff, res_cal_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [gbdi_pkg::ANGLE_W-1:0]           rsp_angle_ff, rsp_angle_in;
   logic                                   rsp_cal_ff, rsp_cal_in;

   logic                                   req_beat;
   logic signed [gbdi_pkg::RATE_W-1:0]     rate_s;
   logic [gbdi_pkg::TS_W-1:0]              now_ts;
   logic signed [gbdi_pkg::SUM_W-1:0]      sum_next;
   logic signed [gbdi_pkg::SUM_W-1:0]      sum_shr;
   logic signed [gbdi_pkg::CORR_W-1:0]     corr;
   logic [gbdi_pkg::CORR_W-1:0]            corr_mag;
   logic [gbdi_pkg::TS_W-1:0]              ts_diff;
   logic [gbdi_pkg::DT_W-1:0]              dt;

   logic                                   mult_start;
   logic [gbdi_pkg::MA_W-1:0]              mult_a;
   logic [gbdi_pkg::MB_W-1:0]              mult_b;
   gbdi_pkg::mult_stat_type                mult_stat;
   logic [gbdi_pkg::MP_W-1:0]              mult_p;
   logic                                   acc_en;
   logic [gbdi_pkg::ANGLE_W-1:0]           acc_angle;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Sample decode
   assign rate_s = gbdi_pkg::rate_ext(req_tdata[gbdi_pkg::SAMPLE_W-1:0]);
   assign now_ts = req_tdata[gbdi_pkg::SAMPLE_W+gbdi_pkg::TS_W-1:gbdi_pkg::SAMPLE_W];

   // Calibration running sum and floor-shifted bias
   assign sum_next = rate_sum_ff + gbdi_pkg::SUM_W'(rate_s);
   assign sum_shr  = sum_next >>> gbdi_pkg::CAL_SHIFT;

   // Bias removal, magnitude for the deadband and the multiplier
   assign corr     = gbdi_pkg::CORR_W'(rate_s) - gbdi_pkg::CORR_W'(bias_ff);
   assign corr_mag = corr[gbdi_pkg::CORR_W-1] ? gbdi_pkg::CORR_W'(-corr)
                                              : gbdi_pkg::CORR_W'(corr);

   // Elapsed time wraps modulo 2^32 and saturates to the dt width
   assign ts_diff = now_ts - last_ts_ff;
   assign dt      = (ts_diff[gbdi_pkg::TS_W-1:gbdi_pkg::DT_W] != '0) ? '1
                                                                    : ts_diff[gbdi_pkg::DT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cal_active_in = cal_active_ff;
      cal_count_in  = cal_count_ff;
      rate_sum_in   = rate_sum_ff;
      bias_in       = bias_ff;
      last_ts_in    = last_ts_ff;
      deadband_in   = deadband_ff;
      scale_in      = scale_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      res_cal_in    = res_cal_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_cal_in    = rsp_cal_ff;
      mult_start    = 1'b0;
      mult_a        = gbdi_pkg::MA_W'(scale_ff);
      mult_b        = gbdi_pkg::MB_W'(dt);
      acc_en        = 1'b0;

      // Register writes; indexes beyond the list fall through
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gbdi_pkg::REG_DEADBAND: deadband_in = csr_data[gbdi_pkg::DEADBAND_W-1:0];
            gbdi_pkg::REG_SCALE:    scale_in    = csr_data[gbdi_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end

      // Drop the output beat once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (cal_active_ff) begin
                  rate_sum_in  = sum_next;
                  cal_count_in = cal_count_ff + 1'b1;
                  if (cal_count_ff == gbdi_pkg::CNT_W'(gbdi_pkg::CAL_SAMPLES - 1)) begin
                     // last calibration sample: latch bias and reference time
                     bias_in       = gbdi_pkg::BIAS_W'(sum_shr);
                     last_ts_in    = now_ts;
                     cal_active_in = 1'b0;
                  end
                  res_cal_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  last_ts_in = now_ts;
                  // magnitude strictly below the deadband counts as zero
                  mag_in     = (gbdi_pkg::CMP_W'(corr_mag) < gbdi_pkg::CMP_W'(deadband_ff))
                             ? '0 : corr_mag;
                  neg_in     = corr[gbdi_pkg::CORR_W-1];
                  res_cal_in = 1'b0;
                  mult_start = 1'b1;   // first pass: dt * scale
                  state_in   = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            if (mult_stat.done) begin
               // second pass: (dt * scale) * |rate|
               mult_start = 1'b1;
               mult_a     = mult_p[gbdi_pkg::MA_W-1:0];
               mult_b     = gbdi_pkg::MB_W'(mag_ff);
               state_in   = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mult_stat.done) begin
               acc_en   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = res_cal_ff ? '0 : acc_angle;
               rsp_cal_in   = res_cal_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      res_cal_ff   <= res_cal_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_cal_ff   <= rsp_cal_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         cal_active_ff <= 1'b1;
         cal_count_ff  <= '0;
         rate_sum_ff   <= '0;
         bias_ff       <= '0;
         last_ts_ff    <= '0;
         deadband_ff   <= gbdi_pkg::DEADBAND_RST;
         scale_ff      <= gbdi_pkg::SCALE_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cal_active_ff <= cal_active_in;
         cal_count_ff  <= cal_count_in;
         rate_sum_ff   <= rate_sum_in;
         bias_ff       <= bias_in;
         last_ts_ff    <= last_ts_in;
         deadband_ff   <= deadband_in;
         scale_ff      <= scale_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   gbdi_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mult_start),
      .mcand   (mult_a),
      .mplier  (mult_b),
      .stat    (mult_stat),
      .product (mult_p)
   );

   gbdi_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .add_en   (acc_en),
      .prod_mag (mult_p),
      .prod_neg (neg_ff),
      .angle    (acc_angle)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_angle_ff;
   assign rsp_tuser[0] = rsp_cal_ff;

endmodule

// ===== design/gbdi_serial_mult.sv =====
// Unsigned shift-add multiplier that retires one multiplier bit per cycle.
module gbdi_serial_mult (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gbdi_pkg::MA_W-1:0]      mcand,
   input  logic [gbdi_pkg::MB_W-1:0]      mplier,
   output gbdi_pkg::mult_stat_type        stat,
   output logic [gbdi_pkg::MP_W-1:0]      product
);

   logic [gbdi_pkg::MA_W-1:0]   mcand_ff, mcand_in;
   logic [gbdi_pkg::MP_W-1:0]   prod_ff, prod_in;
   logic [gbdi_pkg::MCNT_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [gbdi_pkg::MA_W:0]     step_sum;

   // Add the multiplicand into the upper half when the current bit is set
   assign step_sum = {1'b0, prod_ff[gbdi_pkg::MP_W-1:gbdi_pkg::MB_W]}
                   + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = mcand;
         prod_in  = {{gbdi_pkg::MA_W{1'b0}}, mplier};
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {step_sum, prod_ff[gbdi_pkg::MB_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == gbdi_pkg::MCNT_W'(gbdi_pkg::MB_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = prod_ff;

endmodule

// ===== design/gbdi_accum.sv =====
// Saturating Q16 angle accumulator with a clamped 32-bit millidegree view.
module gbdi_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           add_en,
   input  logic [gbdi_pkg::MP_W-1:0]      prod_mag,
   input  logic                           prod_neg,
   output logic [gbdi_pkg::ANGLE_W-1:0]   angle
);

   logic signed [gbdi_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [gbdi_pkg::MP_W:0]    term;
   logic signed [gbdi_pkg::ACC_W:0]   sum;
   logic [gbdi_pkg::ACC_W-gbdi_pkg::FRAC_W-gbdi_pkg::ANGLE_W:0] hi;

   assign term = prod_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
   assign sum  = (gbdi_pkg::ACC_W + 1)'(acc_ff) + (gbdi_pkg::ACC_W + 1)'(term);

   always_comb begin
      acc_in = acc_ff;
      if (add_en) begin
         if (sum[gbdi_pkg::ACC_W] != sum[gbdi_pkg::ACC_W-1]) begin
            // clamp at the signed limits instead of wrapping
            acc_in = sum[gbdi_pkg::ACC_W] ? {1'b1, {(gbdi_pkg::ACC_W-1){1'b0}}}
                                          : {1'b0, {(gbdi_pkg::ACC_W-1){1'b1}}};
         end else begin
            acc_in = sum[gbdi_pkg::ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Floor shift by the fraction, then clamp to the output range
   assign hi = acc_ff[gbdi_pkg::ACC_W-1:gbdi_pkg::FRAC_W+gbdi_pkg::ANGLE_W-1];

   always_comb begin
      if (hi == '0 || hi == '1) begin
         angle = acc_ff[gbdi_pkg::FRAC_W+gbdi_pkg::ANGLE_W-1:gbdi_pkg::FRAC_W];
      end else if (acc_ff[gbdi_pkg::ACC_W-1]) begin
         angle = {1'b1, {(gbdi_pkg::ANGLE_W-1){1'b0}}};
      end else begin
         angle = {1'b0, {(gbdi_pkg::ANGLE_W-1){1'b1}}};
      end
   end

endmodule

// ===== design/gbdi_checker.sv =====
// Port-level checks for the gyro bias deadband integrator, bound to the top level.
module gbdi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [31:0]                       rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Calibration beats always report a zero angle
   a_cal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("nonzero angle during calibration");

   // One sample at a time: ready drops right after an accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a sample is in flight");

   // Calibration never comes back once integration results have been delivered
   a_cal_once: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tuser[0] |=> !(rsp_tvalid && rsp_tuser[0]))
      else $error("calibration result after integration started");

endmodule

bind gyro_bias_deadband_integrator gbdi_checker u_gbdi_checker (.*);

// ===== verif/gyro_bias_deadband_integrator_tb.sv =====
// Self-checking testbench for the gyro yaw-rate integrator: calibration, deadband, integration.
`timescale 1ns / 1ps

module gyro_bias_deadband_integrator_tb;

   // One input beat: raw rate and millisecond stamp
   typedef struct packed {
      logic signed [15:0] rate;
      logic [31:0]        stamp;
   } gyro_sample_type;

   // One result beat: saturated angle and calibrating flag
   typedef struct packed {
      logic [31:0] angle;
      logic        calibrating;
   } angle_result_type;

   // Receiver stall patterns
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   localparam int     BIAS_SHIFT = $clog2(gbdi_pkg::CAL_SAMPLES + 1) - 1;
   localparam longint ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN    = -ACC_MAX - 1;
   localparam longint ANGLE_MAX  = 64'sd2147483647;
   localparam longint ANGLE_MIN  = -64'sd2147483648;
   localparam int     SETTLE     = 60;      // comfortably above the time one integrating sample takes
   localparam int     LONG_HOLD  = 600;     // receiver hold-off used to back up the block

   // DUT ports, all inputs known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [gbdi_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gbdi_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // Predictor state, tracks the block beat by beat
   logic                            cal_on     = 1'b1;
   int                              cal_seen   = 0;
   longint                          rate_total = 0;
   longint                          bias_value = 0;
   logic [31:0]                     stamp_prev = '0;
   longint                          angle_acc  = 0;
   logic [gbdi_pkg::DEADBAND_W-1:0] band_cfg   = gbdi_pkg::DEADBAND_RST;
   logic [gbdi_pkg::SCALE_W-1:0]    scale_cfg  = gbdi_pkg::SCALE_RST;

   // Pending input beats and the angles they must produce
   gyro_sample_type  sample_q[$];
   angle_result_type angle_q[$];

   int               fail_count = 0;
   logic             req_taken  = 1'b0;
   gyro_sample_type  next_sample;
   angle_result_type want;

   // Sender pacing
   int burst_left = 1;
   int gap_left   = 0;

   // Receiver pacing
   rx_mode_type rx_mode        = RX_OPEN;
   int          rx_mode_left   = 0;
   int          rx_tick        = 0;
   int          long_hold_left = 0;
   logic        long_hold_arm  = 1'b0;
   logic        long_hold_done = 1'b0;

   // Stimulus bookkeeping
   logic [31:0] gen_ts = '0;
   int          bias_int;
   int          cal_base;

   gyro_bias_deadband_integrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Advance the integrator by one accepted beat and return the angle it must report.
   function automatic angle_result_type integrate_sample(input logic [47:0] beat);
      logic signed [15:0] rate;
      logic [31:0]        now;
      logic [31:0]        dt;
      longint             corr;
      longint             mag;
      longint             prod;
      longint             whole;
      angle_result_type   res;
      rate = beat[15:0];
      now  = beat[47:16];
      if (cal_on) begin
         // Calibration: sum the rate, fix the bias on the last one
         rate_total += longint'(rate);
         cal_seen++;
         if (cal_seen >= gbdi_pkg::CAL_SAMPLES) begin
            bias_value = rate_total >>> BIAS_SHIFT;
            stamp_prev = now;
            cal_on     = 1'b0;
         end
         res.angle       = '0;
         res.calibrating = 1'b1;
         return res;
      end
      corr = longint'(rate) - bias_value;
      mag  = (corr < 0) ? -corr : corr;
      // Elapsed time wraps mod 2^32, so a backward stamp saturates
      dt = now - stamp_prev;
      if (dt > 32'd65535)
         dt = 32'd65535;
      stamp_prev = now;
      if (mag < longint'(band_cfg))
         corr = 0;
      prod = corr * longint'(dt) * longint'(scale_cfg);
      // Saturating add into the Q16 accumulator
      if (prod > 0 && angle_acc > ACC_MAX - prod)
         angle_acc = ACC_MAX;
      else if (prod < 0 && angle_acc < ACC_MIN - prod)
         angle_acc = ACC_MIN;
      else
         angle_acc = angle_acc + prod;
      whole = angle_acc >>> gbdi_pkg::FRAC_W;
      if (whole > ANGLE_MAX)
         whole = ANGLE_MAX;
      if (whole < ANGLE_MIN)
         whole = ANGLE_MIN;
      res.angle       = whole[31:0];
      res.calibrating = 1'b0;
      return res;
   endfunction

   // Queue one beat with the rate truncated to the field width.
   function automatic void push_sample(input int rate, input logic [31:0] stamp);
      gyro_sample_type s;
      s.rate  = 16'(rate);
      s.stamp = stamp;
      sample_q.push_back(s);
   endfunction

   // Build one integrating beat: mostly steady time steps, with stalls, jumps and
   // backward stamps mixed in; rates cluster on the deadband edge and around the bias.
   function automatic void push_random_sample(input int bias, input int band);
      int pick;
      int rate;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         gen_ts += $urandom_range(1, 40);
      else if (pick < 78) begin
         // hold the stamp: zero elapsed time
      end else if (pick < 85)
         gen_ts += $urandom_range(41, 70000);
      else if (pick < 90)
         gen_ts -= $urandom_range(1, 3000);
      else if (pick < 95)
         gen_ts = $urandom;
      else
         gen_ts += $urandom_range(0, 1) ? 32'd65535 : 32'd65536;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         rate = bias + ($urandom_range(0, 1) ? band : -band) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 70)
         rate = bias + int'($urandom_range(0, 4000)) - 2000;
      else if (pick < 92)
         rate = int'($urandom_range(0, 65535)) - 32768;
      else
         rate = $urandom_range(0, 1) ? 32767 : -32768;
      push_sample(rate, gen_ts);
   endfunction

   // Write one register beat; the predictor copy follows on acceptance.
   task automatic write_reg(input logic [gbdi_pkg::CSR_INDEX_W-1:0] index,
                            input logic [gbdi_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == gbdi_pkg::REG_DEADBAND)
         band_cfg = data[gbdi_pkg::DEADBAND_W-1:0];
      else if (index == gbdi_pkg::REG_SCALE)
         scale_cfg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every queued beat went in and every result came back.
   task automatic drain_results();
      while (sample_q.size() != 0 || req_tvalid || angle_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Driver: change inputs on the falling edge, bursts with random gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the beat until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
         next_sample = sample_q.pop_front();
         req_tdata  <= {next_sample.stamp, next_sample.rate};
         req_tvalid <= 1'b1;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            // pick the next burst and the gap in front of it
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 9))
               0, 1, 2: gap_left = 0;
               3, 4, 5, 6: gap_left = $urandom_range(1, 8);
               7, 8: gap_left = $urandom_range(9, 45);
               default: gap_left = $urandom_range(46, 120);
            endcase
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Long hold-off: count the stalled cycles once armed.
   always @(posedge clock) begin
      if (long_hold_arm && !long_hold_done) begin
         long_hold_done <= 1'b1;
         long_hold_left <= LONG_HOLD;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // Receiver: its own stall pattern, held off while the long hold-off runs.
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= ((rx_tick % 7) < 3);
         endcase
         rx_tick++;
      end
   end

   // Monitor: sample on the rising edge, check results first, then predict new beats.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (angle_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: angle %0d cal %0b",
                           $signed(rsp_tdata), rsp_tuser[0]);
            end else begin
               want = angle_q.pop_front();
               if (rsp_tdata !== want.angle || rsp_tuser[0] !== want.calibrating) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("angle mismatch: expected %0d cal %0b, got %0d cal %0b",
                              $signed(want.angle), want.calibrating,
                              $signed(rsp_tdata), rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready)
            angle_q.push_back(integrate_sample(req_tdata));
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("gyro_bias_deadband_integrator test failed");
      $finish;
   end

   // Phases: calibration, then several register settings, each drained before the next write.
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Indexes past the two registers must leave the defaults alone
      write_reg(4'd15, 16'hFFFF);
      write_reg(4'd2, 16'h0000);

      // Calibration: extremes first, then samples spread around a random offset
      gen_ts   = $urandom;
      cal_base = int'($urandom_range(0, 4000)) - 2000;
      push_sample(32767, gen_ts);
      gen_ts += 3;
      push_sample(-32768, gen_ts);
      gen_ts += 3;
      push_sample(0, gen_ts);
      gen_ts += 3;
      push_sample(-1, gen_ts);
      repeat (gbdi_pkg::CAL_SAMPLES - 4) begin
         if ($urandom_range(0, 19) == 0)
            gen_ts = $urandom;
         else
            gen_ts += $urandom_range(1, 20);
         push_sample(cal_base + int'($urandom_range(0, 600)) - 300, gen_ts);
      end
      drain_results();
      bias_int = int'(bias_value);

      // Reset defaults: zero elapsed time, both deadband edges, dt saturation,
      // a backward stamp, rate extremes and a stamp that wraps
      gen_ts += 0;
      push_sample(bias_int + 1000, gen_ts);
      gen_ts += 1;
      push_sample(bias_int + 149, gen_ts);
      gen_ts += 1;
      push_sample(bias_int + 150, gen_ts);
      gen_ts += 1;
      push_sample(bias_int - 150, gen_ts);
      gen_ts += 1;
      push_sample(bias_int - 149, gen_ts);
      gen_ts += 65535;
      push_sample(bias_int + 500, gen_ts);
      gen_ts += 65536;
      push_sample(bias_int - 500, gen_ts);
      gen_ts -= 5;
      push_sample(bias_int + 300, gen_ts);
      gen_ts += 10;
      push_sample(32767, gen_ts);
      gen_ts += 10;
      push_sample(-32768, gen_ts);
      gen_ts = 32'hFFFF_FFF8;
      push_sample(bias_int + 700, gen_ts);
      gen_ts = 32'd3;
      push_sample(bias_int + 700, gen_ts);
      repeat (100) push_random_sample(bias_int, band_cfg);
      drain_results();

      // No deadband, full scale: drive the angle into both clamps and back
      write_reg(gbdi_pkg::REG_DEADBAND, 16'd0);
      write_reg(gbdi_pkg::REG_SCALE, 16'hFFFF);
      gen_ts += 5;
      push_sample(bias_int, gen_ts);
      repeat (2) begin
         gen_ts += 100000;
         push_sample(bias_int + 30000, gen_ts);
      end
      repeat (4) begin
         gen_ts += 100000;
         push_sample(bias_int - 30000, gen_ts);
      end
      repeat (2) begin
         gen_ts += 100000;
         push_sample(bias_int + 30000, gen_ts);
      end
      repeat (150) push_random_sample(bias_int, band_cfg);
      drain_results();

      // Widest deadband, written with bit 15 set to check the masking
      write_reg(gbdi_pkg::REG_DEADBAND, 16'hFFFF);
      write_reg(gbdi_pkg::REG_SCALE, 16'($urandom_range(1, 65535)));
      write_reg(4'($urandom_range(2, 15)), 16'($urandom));
      repeat (120) push_random_sample(bias_int, band_cfg);
      drain_results();

      // Zero scale: the angle must stay put
      write_reg(gbdi_pkg::REG_DEADBAND, 16'($urandom_range(0, 2000)));
      write_reg(gbdi_pkg::REG_SCALE, 16'd0);
      repeat (100) push_random_sample(bias_int, band_cfg);
      drain_results();

      // Random setting; the receiver holds off long enough to back up the input
      write_reg(gbdi_pkg::REG_DEADBAND, 16'($urandom_range(0, 600)));
      write_reg(gbdi_pkg::REG_SCALE, 16'($urandom_range(0, 65535)));
      write_reg(4'($urandom_range(2, 15)), 16'($urandom));
      repeat (150) push_random_sample(bias_int, band_cfg);
      long_hold_arm = 1'b1;
      drain_results();

      if (fail_count == 0 && angle_q.size() == 0)
         $display("gyro_bias_deadband_integrator test passed");
      else
         $display("gyro_bias_deadband_integrator test failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/gbdi_pkg.sv
design/gbdi_serial_mult.sv
design/gbdi_accum.sv
design/gyro_bias_deadband_integrator.sv
design/gbdi_checker.sv
verif/gyro_bias_deadband_integrator_tb.sv
